### rtl/rsm_pkg.sv
package rsm_pkg;

    localparam int ROUTE_ROWS_DEF = 16;
    localparam int ROUTE_LEN_DEF  = 256;

    localparam logic [2:0] REQ_WRITE = 3'd0;
    localparam logic [2:0] REQ_READ  = 3'd1;
    localparam logic [2:0] REQ_FLIP  = 3'd2;
    localparam logic [2:0] REQ_SWAP  = 3'd3;
    localparam logic [2:0] REQ_SLIDE = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  row;
        logic [7:0]  pos_first;
        logic [7:0]  pos_second;
        logic [15:0] write_value;
    } req_t;

    typedef struct packed {
        logic [15:0] read_value;
        logic        status;
    } rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WRITE,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_X_RD_LO,
        ST_X_RD_HI,
        ST_X_WR_LO,
        ST_X_WR_HI,
        ST_SL_HEAD,
        ST_SL_NEXT,
        ST_SL_MOVE,
        ST_SL_TAIL,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        RA_LO,
        RA_HI,
        RA_LO1,
        RA_LO2
    } raddr_sel_t;

    typedef enum logic [1:0] {
        WD_REQ,
        WD_RDATA,
        WD_HOLD
    } wdata_sel_t;

    typedef struct packed {
        logic       load;
        logic       we;
        logic       waddr_hi;
        wdata_sel_t wdata_sel;
        raddr_sel_t raddr_sel;
        logic       cap_hold;
        logic       cap_value;
        logic       step_pair;
        logic       step_lo;
        logic       finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       reject;
        logic       in_range;
        logic       seg_open;
        logic       pair_more;
        logic       slide_more;
    } dp_stat_t;

endpackage

### rtl/rsm_ram.sv
module rsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/rsm_ctrl.sv
module rsm_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rsm_pkg::dp_stat_t   stat,
    output rsm_pkg::ctrl_cmd_t  cmd,
    output logic                busy
);

    rsm_pkg::state_t state_reg;
    rsm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rsm_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = rsm_pkg::ST_CHECK;
                end
            end
            rsm_pkg::ST_CHECK:
            begin
                priority if (stat.reject || !stat.in_range)
                begin
                    state_next = rsm_pkg::ST_FINISH;
                end
                else if (stat.kind == rsm_pkg::REQ_WRITE)
                begin
                    state_next = rsm_pkg::ST_WRITE;
                end
                else if (stat.kind == rsm_pkg::REQ_READ)
                begin
                    state_next = rsm_pkg::ST_RD_ADDR;
                end
                else if (stat.kind == rsm_pkg::REQ_SWAP
                         || (stat.kind == rsm_pkg::REQ_FLIP && stat.seg_open))
                begin
                    state_next = rsm_pkg::ST_X_RD_LO;
                end
                else if (stat.kind == rsm_pkg::REQ_SLIDE && stat.seg_open)
                begin
                    state_next = rsm_pkg::ST_SL_HEAD;
                end
                else
                begin
                    state_next = rsm_pkg::ST_FINISH;
                end
            end
            rsm_pkg::ST_WRITE:   state_next = rsm_pkg::ST_FINISH;
            rsm_pkg::ST_RD_ADDR: state_next = rsm_pkg::ST_RD_DATA;
            rsm_pkg::ST_RD_DATA: state_next = rsm_pkg::ST_FINISH;
            rsm_pkg::ST_X_RD_LO: state_next = rsm_pkg::ST_X_RD_HI;
            rsm_pkg::ST_X_RD_HI: state_next = rsm_pkg::ST_X_WR_LO;
            rsm_pkg::ST_X_WR_LO: state_next = rsm_pkg::ST_X_WR_HI;
            rsm_pkg::ST_X_WR_HI:
            begin
                if (stat.kind == rsm_pkg::REQ_FLIP && stat.pair_more)
                begin
                    state_next = rsm_pkg::ST_X_RD_HI;
                end
                else
                begin
                    state_next = rsm_pkg::ST_FINISH;
                end
            end
            rsm_pkg::ST_SL_HEAD: state_next = rsm_pkg::ST_SL_NEXT;
            rsm_pkg::ST_SL_NEXT: state_next = rsm_pkg::ST_SL_MOVE;
            rsm_pkg::ST_SL_MOVE:
            begin
                if (!stat.slide_more)
                begin
                    state_next = rsm_pkg::ST_SL_TAIL;
                end
            end
            rsm_pkg::ST_SL_TAIL: state_next = rsm_pkg::ST_FINISH;
            rsm_pkg::ST_FINISH:  state_next = rsm_pkg::ST_IDLE;
            default:             state_next = rsm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.wdata_sel = rsm_pkg::WD_REQ;
        cmd.raddr_sel = rsm_pkg::RA_LO;
        unique case (state_reg)
            rsm_pkg::ST_IDLE:
            begin
                cmd.load = start;
            end
            rsm_pkg::ST_WRITE:
            begin
                cmd.we = 1'b1;
            end
            rsm_pkg::ST_RD_DATA:
            begin
                cmd.cap_value = 1'b1;
            end
            rsm_pkg::ST_X_RD_HI:
            begin
                cmd.raddr_sel = rsm_pkg::RA_HI;
                cmd.cap_hold  = 1'b1;
            end
            rsm_pkg::ST_X_WR_LO:
            begin
                cmd.we        = 1'b1;
                cmd.wdata_sel = rsm_pkg::WD_RDATA;
            end
            rsm_pkg::ST_X_WR_HI:
            begin
                // read of the next low entry overlaps the high write
                cmd.we        = 1'b1;
                cmd.waddr_hi  = 1'b1;
                cmd.wdata_sel = rsm_pkg::WD_HOLD;
                cmd.raddr_sel = rsm_pkg::RA_LO1;
                cmd.step_pair = 1'b1;
            end
            rsm_pkg::ST_SL_NEXT:
            begin
                cmd.raddr_sel = rsm_pkg::RA_LO1;
                cmd.cap_hold  = 1'b1;
            end
            rsm_pkg::ST_SL_MOVE:
            begin
                cmd.we        = 1'b1;
                cmd.wdata_sel = rsm_pkg::WD_RDATA;
                cmd.raddr_sel = rsm_pkg::RA_LO2;
                cmd.step_lo   = 1'b1;
            end
            rsm_pkg::ST_SL_TAIL:
            begin
                cmd.we        = 1'b1;
                cmd.waddr_hi  = 1'b1;
                cmd.wdata_sel = rsm_pkg::WD_HOLD;
            end
            rsm_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign busy = (state_reg != rsm_pkg::ST_IDLE);

endmodule

### rtl/rsm_datapath.sv
module rsm_datapath #(
    parameter int ROUTE_ROWS = rsm_pkg::ROUTE_ROWS_DEF,
    parameter int ROUTE_LEN  = rsm_pkg::ROUTE_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  rsm_pkg::req_t      req,
    input  rsm_pkg::ctrl_cmd_t cmd,
    output rsm_pkg::dp_stat_t  stat,
    output rsm_pkg::rsp_t      rsp,
    output logic               done
);

    localparam int ROW_W  = (ROUTE_ROWS > 1) ? $clog2(ROUTE_ROWS) : 1;
    localparam int POS_W  = $clog2(ROUTE_LEN);
    localparam int ADDR_W = ROW_W + POS_W;
    localparam int DEPTH  = 1 << ADDR_W;

    logic [2:0]  kind_reg;
    logic [3:0]  row_reg;
    logic [7:0]  lo_reg;
    logic [7:0]  hi_reg;
    logic [15:0] wval_reg;
    logic [15:0] hold_reg;
    logic [15:0] value_reg;
    logic        status_reg;
    logic        done_reg;

    logic [7:0]        rpos;
    logic [7:0]        wpos;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic [15:0]       wdata;
    logic [15:0]       rdata;
    logic              row_ok;
    logic              lo_ok;
    logic              hi_ok;
    logic              is_slot_req;

    function automatic logic [ADDR_W-1:0] entry_addr(input logic [3:0] r, input logic [7:0] p);
        logic [31:0] r32;
        logic [31:0] p32;
        r32 = 32'(r);
        p32 = 32'(p);
        return {r32[ROW_W-1:0], p32[POS_W-1:0]};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg   <= req.req_type;
            row_reg    <= req.row;
            lo_reg     <= req.pos_first;
            hi_reg     <= req.pos_second;
            wval_reg   <= req.write_value;
            value_reg  <= '0;
            status_reg <= (req.req_type == rsm_pkg::REQ_FLIP
                           || req.req_type == rsm_pkg::REQ_SLIDE)
                          && (req.pos_first > req.pos_second);
        end
        else
        begin
            if (cmd.step_pair)
            begin
                lo_reg <= lo_reg + 8'd1;
                hi_reg <= hi_reg - 8'd1;
            end
            else if (cmd.step_lo)
            begin
                lo_reg <= lo_reg + 8'd1;
            end
            if (cmd.cap_value)
            begin
                value_reg <= rdata;
            end
        end
        if (cmd.cap_hold)
        begin
            hold_reg <= rdata;
        end
    end

    always_comb
    begin
        unique case (cmd.raddr_sel)
            rsm_pkg::RA_LO:  rpos = lo_reg;
            rsm_pkg::RA_HI:  rpos = hi_reg;
            rsm_pkg::RA_LO1: rpos = lo_reg + 8'd1;
            rsm_pkg::RA_LO2: rpos = lo_reg + 8'd2;
            default:         rpos = lo_reg;
        endcase
        unique case (cmd.wdata_sel)
            rsm_pkg::WD_REQ:   wdata = wval_reg;
            rsm_pkg::WD_RDATA: wdata = rdata;
            rsm_pkg::WD_HOLD:  wdata = hold_reg;
            default:           wdata = wval_reg;
        endcase
    end

    assign wpos  = cmd.waddr_hi ? hi_reg : lo_reg;
    assign raddr = entry_addr(row_reg, rpos);
    assign waddr = entry_addr(row_reg, wpos);

    rsm_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign row_ok      = 32'(row_reg) < ROUTE_ROWS;
    assign lo_ok       = 32'(lo_reg) < ROUTE_LEN;
    assign hi_ok       = 32'(hi_reg) < ROUTE_LEN;
    assign is_slot_req = (kind_reg == rsm_pkg::REQ_WRITE) || (kind_reg == rsm_pkg::REQ_READ);

    always_comb
    begin
        stat.kind       = kind_reg;
        stat.reject     = status_reg;
        stat.in_range   = row_ok && lo_ok && (is_slot_req || hi_ok);
        stat.seg_open   = lo_reg < hi_reg;
        stat.pair_more  = (9'(lo_reg) + 9'd2) < 9'(hi_reg);
        stat.slide_more = (9'(lo_reg) + 9'd1) < 9'(hi_reg);
    end

    assign rsp.read_value = value_reg;
    assign rsp.status     = status_reg;
    assign done           = done_reg;

endmodule

### rtl/route_segment_mutator_core.sv
// Flip repeats its read and write steps for each exchanged pair and slide its move
// step for each moved entry; rejected or empty requests go straight to done. The
// per-pair and per-entry steps come from the one-port-each route RAM.
// A new transaction is accepted in the cycle its predecessor's done strobe shows.
// The receiver cannot stall: results are valid for the single done cycle.
// rst_n clears control only; route RAM contents are undefined until written.
module route_segment_mutator_core #(
    parameter int ROUTE_ROWS = rsm_pkg::ROUTE_ROWS_DEF,
    parameter int ROUTE_LEN  = rsm_pkg::ROUTE_LEN_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  rsm_pkg::req_t req,
    output logic          busy,
    output logic          done,
    output rsm_pkg::rsp_t rsp
);

    rsm_pkg::ctrl_cmd_t cmd;
    rsm_pkg::dp_stat_t  stat;

    rsm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    rsm_datapath #(
        .ROUTE_ROWS (ROUTE_ROWS),
        .ROUTE_LEN  (ROUTE_LEN)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp),
        .done  (done)
    );

endmodule

### bench/route_bench_pkg.sv
`timescale 1ns / 1ps
package route_bench_pkg;
    import rsm_pkg::*;

    localparam int ROWS  = ROUTE_ROWS_DEF;
    localparam int LEN   = ROUTE_LEN_DEF;
    localparam int CELLS = ROWS * LEN;

    // request codes the block must ignore
    localparam logic [2:0] REQ_NONE_A = 3'd5;
    localparam logic [2:0] REQ_NONE_B = 3'd6;
    localparam logic [2:0] REQ_NONE_C = 3'd7;

    localparam int REPORT_LIMIT = 10;

    class route_mirror;
        bit [15:0] entry [CELLS];
        bit        written [CELLS];
        rsp_t      expected_rsp [$];
        int        mismatches = 0;

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("[%0t] %s", $realtime, msg);
        endfunction

        function bit is_written(int row, int pos);
            return written[row * LEN + pos];
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        function void exchange(int a, int b);
            bit [15:0] v;
            bit        w;
            v = entry[a];
            w = written[a];
            entry[a] = entry[b];
            written[a] = written[b];
            entry[b] = v;
            written[b] = w;
        endfunction

        // predicts the response of one accepted transaction and updates the route copy
        function void note_request(req_t r);
            rsp_t      want;
            int        base;
            int        p1;
            int        p2;
            int        lo;
            int        hi;
            bit        row_ok;
            bit        both_ok;
            bit [15:0] head;
            bit        head_w;
            want = '0;
            base = int'(r.row) * LEN;
            p1 = int'(r.pos_first);
            p2 = int'(r.pos_second);
            row_ok = int'(r.row) < ROWS;
            both_ok = p1 < LEN && p2 < LEN;
            case (r.req_type)
                REQ_WRITE:
                    if (row_ok && p1 < LEN)
                    begin
                        entry[base + p1] = r.write_value;
                        written[base + p1] = 1'b1;
                    end
                REQ_READ:
                    if (row_ok && p1 < LEN)
                        want.read_value = entry[base + p1];
                REQ_FLIP:
                    if (p1 > p2)
                        want.status = 1'b1;
                    else if (row_ok && both_ok)
                    begin
                        lo = p1;
                        hi = p2;
                        while (lo < hi)
                        begin
                            exchange(base + lo, base + hi);
                            lo++;
                            hi--;
                        end
                    end
                REQ_SWAP:
                    if (row_ok && both_ok)
                        exchange(base + p1, base + p2);
                REQ_SLIDE:
                    if (p1 > p2)
                        want.status = 1'b1;
                    else if (row_ok && both_ok)
                    begin
                        head = entry[base + p1];
                        head_w = written[base + p1];
                        for (int k = p1; k < p2; k++)
                        begin
                            entry[base + k] = entry[base + k + 1];
                            written[base + k] = written[base + k + 1];
                        end
                        entry[base + p2] = head;
                        written[base + p2] = head_w;
                    end
                default:
                    ;
            endcase
            expected_rsp.push_back(want);
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                flag($sformatf("unexpected response: read_value %h status %b",
                               got.read_value, got.status));
                return;
            end
            want = expected_rsp.pop_front();
            if (got.read_value !== want.read_value || got.status !== want.status)
                flag($sformatf("response mismatch: expected read_value %h status %b, got read_value %h status %b",
                               want.read_value, want.status, got.read_value, got.status));
        endfunction
    endclass

endpackage

### bench/route_segment_mutator_core_test.sv
`timescale 1ns / 1ps
module route_segment_mutator_core_test;
    import rsm_pkg::*;
    import route_bench_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int RANDOM_ITEMS   = 1650;

    logic clk = 1'b0;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;

    route_mirror mirror;
    int          issued;
    int          stall_cycles;
    bit          steady;

    route_segment_mutator_core #(
        .ROUTE_ROWS(ROWS),
        .ROUTE_LEN (LEN)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .req  (req),
        .busy (busy),
        .done (done),
        .rsp  (rsp)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            mirror.check_response(rsp);
    end

    // counts cycles in which no transaction moves in either direction
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles = 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            stall_cycles++;
    end

    function req_t make_req(logic [2:0] kind, int row, int p1, int p2, logic [15:0] val);
        req_t r;
        r.req_type = kind;
        r.row = 4'(row);
        r.pos_first = 8'(p1);
        r.pos_second = 8'(p2);
        r.write_value = val;
        return r;
    endfunction

    task issue(req_t r);
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        mirror.note_request(r);
        issued++;
        steady = issued >= 700 && issued < 1000;
        if (!steady && $urandom_range(0, 99) < 35)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // a position in the row that holds a written value, or -1
    function int readable_pos(int row, int lo, int hi);
        int p;
        for (int i = 0; i < 8; i++)
        begin
            p = $urandom_range(lo, hi);
            if (mirror.is_written(row, p))
                return p;
        end
        for (int i = 0; i < 8; i++)
        begin
            p = $urandom_range(0, LEN - 1);
            if (mirror.is_written(row, p))
                return p;
        end
        for (p = 0; p < LEN; p++)
            if (mirror.is_written(row, p))
                return p;
        return -1;
    endfunction

    task mutate_window(int row, int lo, int hi);
        int          p1;
        int          p2;
        int          t;
        int          rd;
        int          pick;
        logic [15:0] val;
        val = 16'($urandom);
        if ($urandom_range(0, 99) < 20)
        begin
            p1 = $urandom_range(0, LEN - 1);
            p2 = $urandom_range(0, LEN - 1);
        end
        else
        begin
            p1 = $urandom_range(lo, hi);
            p2 = $urandom_range(lo, hi);
        end
        // keep most segments in order so mutations take effect
        if (p1 > p2 && $urandom_range(0, 99) < 85)
        begin
            t = p1;
            p1 = p2;
            p2 = t;
        end
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            rd = readable_pos(row, lo, hi);
            if (rd < 0)
                issue(make_req(REQ_WRITE, row, p1, p2, val));
            else
                issue(make_req(REQ_READ, row, rd, p2, val));
        end
        else if (pick < 50)
            issue(make_req(REQ_FLIP, row, p1, p2, val));
        else if (pick < 65)
            issue(make_req(REQ_SWAP, row, p1, p2, val));
        else if (pick < 85)
            issue(make_req(REQ_SLIDE, row, p1, p2, val));
        else if (pick < 93)
            issue(make_req(REQ_WRITE, row, p1, p2, val));
        else
            issue(make_req(3'($urandom_range(REQ_NONE_A, REQ_NONE_C)), row, p1, p2, val));
    endtask

    // fill a short window of one row, then work on it
    task run_episode();
        int row;
        int len;
        int lo;
        row = $urandom_range(0, ROWS - 1);
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        lo = $urandom_range(0, LEN - len);
        for (int p = lo; p < lo + len; p++)
            issue(make_req(REQ_WRITE, row, p, $urandom_range(0, LEN - 1), 16'($urandom)));
        repeat ($urandom_range(3, 10)) mutate_window(row, lo, lo + len - 1);
    endtask

    initial
    begin
        mirror = new;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        issued = 0;
        stall_cycles = 0;
        steady = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue(make_req(REQ_WRITE, 3, 0, 0, 16'h0000));
        issue(make_req(REQ_WRITE, 3, 1, 0, 16'hFFFF));
        issue(make_req(REQ_WRITE, 3, 2, 0, 16'h1234));
        issue(make_req(REQ_WRITE, 3, 3, 0, 16'hABCD));
        issue(make_req(REQ_WRITE, 3, 4, 0, 16'h5555));
        issue(make_req(REQ_WRITE, 3, 5, 0, 16'hAAAA));
        issue(make_req(REQ_WRITE, 15, 255, 255, 16'hFFFF));
        issue(make_req(REQ_WRITE, 15, 254, 0, 16'h8001));
        issue(make_req(REQ_WRITE, 0, 0, 0, 16'h0001));
        issue(make_req(REQ_READ, 3, 1, 0, 16'h0000));
        issue(make_req(REQ_FLIP, 3, 0, 5, 16'h0000));
        issue(make_req(REQ_READ, 3, 0, 0, 16'h0000));
        // swap takes its positions in either order
        issue(make_req(REQ_SWAP, 3, 5, 1, 16'h0000));
        issue(make_req(REQ_SWAP, 3, 2, 2, 16'h0000));
        issue(make_req(REQ_SLIDE, 3, 0, 5, 16'h0000));
        issue(make_req(REQ_READ, 3, 5, 0, 16'h0000));
        // reversed segments are rejected
        issue(make_req(REQ_FLIP, 3, 4, 1, 16'h0000));
        issue(make_req(REQ_SLIDE, 3, 255, 0, 16'hFFFF));
        issue(make_req(REQ_FLIP, 3, 3, 3, 16'h0000));
        issue(make_req(REQ_SLIDE, 3, 2, 2, 16'h0000));
        issue(make_req(REQ_FLIP, 15, 254, 255, 16'h0000));
        issue(make_req(REQ_READ, 15, 255, 255, 16'h0000));
        issue(make_req(REQ_NONE_A, 3, 0, 5, 16'hFFFF));
        issue(make_req(REQ_NONE_B, 15, 255, 255, 16'h0000));
        issue(make_req(REQ_NONE_C, 0, 0, 0, 16'h1234));
        issue(make_req(REQ_READ, 0, 0, 0, 16'h0000));

        while (issued < RANDOM_ITEMS)
            run_episode();

        start <= 1'b0;
        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
